@@ rtl/core/thid_pkg.sv @@
`timescale 1ns / 1ps
// ============================================================================
// thid_pkg
// Shared types, constants and helpers for the tile heatmap ignite/decay block.
// ============================================================================
package thid_pkg;

    // Input operation codes.
    typedef enum logic [1:0] {
        ACT_TICK    = 2'd0,
        ACT_READ    = 2'd1,
        ACT_REGEN   = 2'd2,
        ACT_OVERLAY = 2'd3
    } t_action;

    // Configuration register indexes.
    localparam logic [1:0] CFG_ROWS  = 2'd0;
    localparam logic [1:0] CFG_TILES = 2'd1;
    localparam logic [1:0] CFG_BANDS = 2'd2;

    // Sequencer states of the top level.
    typedef enum logic [2:0] {
        S_IDLE,
        S_RD_WAIT,
        S_RD_OUT,
        S_TICK,
        S_GEN_JIT,
        S_GEN_THR,
        S_GEN_ROW
    } t_state;

    // Phases of the random number unit.
    typedef enum logic [2:0] {
        L_IDLE,
        L_MUL0,
        L_MUL1,
        L_MUL2,
        L_DIV,
        L_MOD
    } t_lcg_ph;

    // Generator constants.
    localparam logic [63:0] LCG_SEED = 64'h0000_C1AB_1A10_15D5;
    localparam logic [63:0] LCG_MUL  = 64'd6364136223846793005;
    localparam logic [63:0] LCG_INC  = 64'd1442695040888963407;

    // Reciprocals that give exact quotients by 5 and by 1000 of a 31-bit draw.
    localparam logic [31:0] LCG_RCP5     = 32'd3435973837;
    localparam int          LCG_RCP5_SH  = 34;
    localparam logic [31:0] LCG_RCP1K    = 32'd2199023256;
    localparam int          LCG_RCP1K_SH = 41;

    // Threshold = 164 + 3k + floor(31k / 1000); the last term by reciprocal.
    localparam logic [11:0] THR_BASE  = 12'd164;
    localparam logic [20:0] THR_RECIP = 21'd1040205;
    localparam int          THR_SHIFT = 25;

    // Intensity constants, 1.0 = 4096.
    localparam logic [12:0] LEVEL_CAP = 13'd4301;
    localparam logic [11:0] DECAY_NUM = 12'd3604;
    localparam logic [12:0] FLOOR_LIM = 13'd4;

    // One store entry.
    typedef struct packed {
        logic [3:0]  band;
        logic [11:0] thr;
        logic [12:0] level;
    } t_cell;

    // Control and status of the random number unit.
    typedef struct packed {
        logic start;
        logic seed;
        logic thou;
    } t_lcg_ctrl;

    typedef struct packed {
        logic       done;
        logic [9:0] rem;
    } t_lcg_stat;

    // Brightness tier of an intensity.
    function automatic logic [2:0] tier_of(input logic [12:0] v);
        logic [2:0] t;
        if (v >= 13'd3482)      t = 3'd6;
        else if (v >= 13'd2663) t = 3'd5;
        else if (v >= 13'd1844) t = 3'd4;
        else if (v >= 13'd1147) t = 3'd3;
        else if (v >= 13'd615)  t = 3'd2;
        else if (v >= 13'd205)  t = 3'd1;
        else                    t = 3'd0;
        return t;
    endfunction

endpackage

@@ rtl/core/tile_heatmap_ignite_decay_top.sv @@
`timescale 1ns / 1ps
// ============================================================================
// tile_heatmap_ignite_decay_top
// Grid of tiles that ignite from spectrum bands and decay each tick.
// ============================================================================
// One item at a time. A read passes through the store's registered read data
// and then the output register to its result. A tick walks the grid through
// the store's read and write ports, one cell per cycle. A regenerate runs the
// LCG on a shared 32x32 multiplier (phases MUL0 to MUL2 per step) followed by
// a reciprocal multiply and a subtract for the remainder, two draws per cell,
// plus a base band update at the start of each new row. Reads before the first
// regenerate, or after a configuration write to rows, tiles or bands, give 0.
module tile_heatmap_ignite_decay_top #(
    parameter int MAX_CELLS = 1024,
    parameter int NUM_BANDS = 10
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_action,
    input  logic [9:0]  i_cell_index,
    input  logic [12:0] i_band_0,
    input  logic [12:0] i_band_1,
    input  logic [12:0] i_band_2,
    input  logic [12:0] i_band_3,
    input  logic [12:0] i_band_4,
    input  logic [12:0] i_band_5,
    input  logic [12:0] i_band_6,
    input  logic [12:0] i_band_7,
    input  logic [12:0] i_band_8,
    input  logic [12:0] i_band_9,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [2:0]  o_brightness_tier,
    output logic [12:0] o_cell_level,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [6:0]  i_cfg_data
);
    import thid_pkg::*;

    localparam int AW = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;
    localparam int CW = $clog2(MAX_CELLS + 1);

    // Configuration registers.
    logic [5:0] r_grid_rows;
    logic [6:0] r_grid_tiles;
    logic [3:0] r_band_count;
    logic       r_grid_ready;

    // Sequencer and datapath registers.
    t_state             r_state, n_state;
    logic [AW-1:0]      r_addr, n_addr;
    logic               r_rd_zero, n_rd_zero;
    logic [CW-1:0]      r_cnt, n_cnt;
    logic               r_p_v, n_p_v;
    logic [AW-1:0]      r_p_addr, n_p_addr;
    logic [12:0]        r_lvl [10];
    logic [5:0]         r_row, n_row;
    logic [6:0]         r_col, n_col;
    logic [AW-1:0]      r_idx, n_idx;
    logic [3:0]         r_q, n_q;
    logic signed [6:0]  r_rem, n_rem;
    logic [3:0]         r_cband, n_cband;
    logic               n_set_ready;
    logic               r_out_valid, n_out_valid;
    logic [2:0]         r_out_tier, n_out_tier;
    logic [12:0]        r_out_level, n_out_level;

    // Store and LCG signals.
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    t_cell         mem_wdata;
    logic [AW-1:0] mem_raddr;
    t_cell         mem_rdata;
    t_lcg_ctrl     lcg_ctrl;
    t_lcg_stat     lcg_stat;

    // Grid dimensions.
    logic [CW-1:0] lim_tab [32];
    logic [5:0]    dim_r;
    logic [6:0]    dim_t;
    logic [CW-1:0] lim;
    logic [12:0]   dim_prod;
    logic [CW-1:0] ncells;
    logic [3:0]    eff_b;

    for (genvar g = 1; g <= 32; g++) begin : g_lim
        localparam int LIM = MAX_CELLS / g;
        assign lim_tab[g-1] = CW'(LIM);
    end

    always_comb begin
        dim_r = r_grid_rows;
        if (dim_r == 6'd0) dim_r = 6'd1;
        if (dim_r > 6'd32) dim_r = 6'd32;
        if (32'(dim_r) > 32'(MAX_CELLS)) dim_r = 6'(MAX_CELLS);
        dim_t = r_grid_tiles;
        if (dim_t == 7'd0) dim_t = 7'd1;
        if (dim_t > 7'd64) dim_t = 7'd64;
        lim = lim_tab[5'(dim_r - 6'd1)];
        if (32'(lim) < 32'(dim_t)) dim_t = 7'(lim);
        dim_prod = 13'(dim_r) * 13'(dim_t);
        ncells   = CW'(dim_prod);
        if (r_band_count == 4'd0) eff_b = 4'(NUM_BANDS);
        else if (32'(r_band_count) > 32'(NUM_BANDS)) eff_b = 4'(NUM_BANDS);
        else eff_b = r_band_count;
    end

    // Tick update of one cell.
    logic [3:0]  bsel;
    logic [12:0] lvl;
    logic [12:0] tk_v;
    logic [24:0] tk_prod;
    logic [12:0] tk_dec;
    logic        ignite;

    always_comb begin
        ignite = (r_band_count != 4'd0);
        bsel   = mem_rdata.band;
        if (32'(bsel) >= 32'(NUM_BANDS)) bsel = 4'(NUM_BANDS - 1);
        lvl  = r_lvl[bsel];
        tk_v = mem_rdata.level;
        if (ignite && lvl > {1'b0, mem_rdata.thr}) begin
            if (lvl > LEVEL_CAP) lvl = LEVEL_CAP;
            if (lvl > tk_v) tk_v = lvl;
        end
        tk_prod = 25'(tk_v) * 25'(DECAY_NUM);
        tk_dec  = tk_prod[24:12];
        if (ignite && tk_dec < FLOOR_LIM) tk_dec = 13'd0;
    end

    // Band and threshold of the cell being generated.
    logic [4:0]  jsum;
    logic [3:0]  jband;
    logic [30:0] k_prod;
    logic [11:0] k_thr;

    always_comb begin
        jsum = {1'b0, r_q} + {2'b00, lcg_stat.rem[2:0]};
        if (jsum < 5'd2) jband = 4'd0;
        else jband = 4'(jsum - 5'd2);
        if (jband > eff_b - 4'd1) jband = eff_b - 4'd1;
        k_prod = 31'(lcg_stat.rem) * 31'(THR_RECIP);
        k_thr  = THR_BASE + 12'(12'(lcg_stat.rem) * 12'd3)
               + 12'(k_prod >> THR_SHIFT);
    end

    // Sequencer.
    logic accept;
    logic out_free;
    logic [12:0] rd_level;

    always_comb begin
        accept   = i_valid && o_ready;
        out_free = !r_out_valid || i_ready;
        rd_level = r_rd_zero ? 13'd0 : mem_rdata.level;

        n_state     = r_state;
        n_addr      = r_addr;
        n_rd_zero   = r_rd_zero;
        n_cnt       = r_cnt;
        n_p_v       = 1'b0;
        n_p_addr    = r_cnt[AW-1:0];
        n_row       = r_row;
        n_col       = r_col;
        n_idx       = r_idx;
        n_q         = r_q;
        n_rem       = r_rem;
        n_cband     = r_cband;
        n_set_ready = 1'b0;
        n_out_valid = r_out_valid && !i_ready;
        n_out_tier  = r_out_tier;
        n_out_level = r_out_level;
        lcg_ctrl    = '0;
        mem_we      = 1'b0;
        mem_waddr   = r_p_addr;
        mem_wdata   = '{band: mem_rdata.band, thr: mem_rdata.thr, level: tk_dec};
        mem_raddr   = (r_state == S_TICK) ? r_cnt[AW-1:0] : r_addr;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    unique case (t_action'(i_action))
                        ACT_TICK: begin
                            n_cnt = '0;
                            if (r_grid_ready) n_state = S_TICK;
                        end
                        ACT_READ: begin
                            n_addr    = AW'(i_cell_index);
                            n_rd_zero = !(r_grid_ready && 32'(i_cell_index) < 32'(ncells));
                            n_state   = S_RD_WAIT;
                        end
                        ACT_REGEN: begin
                            n_row = '0;
                            n_col = '0;
                            n_idx = '0;
                            n_rem = '0;
                            n_q   = (dim_r > 6'd1) ? eff_b - 4'd1 : eff_b >> 1;
                            lcg_ctrl.start = 1'b1;
                            lcg_ctrl.seed  = 1'b1;
                            n_state = S_GEN_JIT;
                        end
                        ACT_OVERLAY: n_state = S_IDLE;
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_RD_WAIT: n_state = S_RD_OUT;
            S_RD_OUT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_level = rd_level;
                    n_out_tier  = tier_of(rd_level);
                    n_state     = S_IDLE;
                end
            end
            S_TICK: begin
                mem_we = r_p_v;
                if (r_cnt < ncells) begin
                    n_p_v = 1'b1;
                    n_cnt = r_cnt + CW'(1);
                end else if (!r_p_v) begin
                    n_state = S_IDLE;
                end
            end
            S_GEN_JIT: begin
                if (lcg_stat.done) begin
                    n_cband        = jband;
                    lcg_ctrl.start = 1'b1;
                    lcg_ctrl.thou  = 1'b1;
                    n_state        = S_GEN_THR;
                end
            end
            S_GEN_THR: begin
                if (lcg_stat.done) begin
                    mem_we    = 1'b1;
                    mem_waddr = r_idx;
                    mem_wdata = '{band: r_cband, thr: k_thr, level: 13'd0};
                    n_idx     = r_idx + AW'(1);
                    if (r_col == dim_t - 7'd1) begin
                        n_col = '0;
                        if (r_row == dim_r - 6'd1) begin
                            n_set_ready = 1'b1;
                            n_state     = S_IDLE;
                        end else begin
                            n_row   = r_row + 6'd1;
                            n_rem   = r_rem - 7'(eff_b - 4'd1);
                            n_state = S_GEN_ROW;
                        end
                    end else begin
                        n_col          = r_col + 7'd1;
                        lcg_ctrl.start = 1'b1;
                        n_state        = S_GEN_JIT;
                    end
                end
            end
            S_GEN_ROW: begin
                // Base band of the new row: restore the running remainder.
                if (r_rem < 0) begin
                    n_rem = r_rem + 7'(dim_r - 6'd1);
                    n_q   = r_q - 4'd1;
                end else begin
                    lcg_ctrl.start = 1'b1;
                    n_state        = S_GEN_JIT;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_p_v        <= 1'b0;
            r_out_valid  <= 1'b0;
            r_grid_ready <= 1'b0;
            r_grid_rows  <= 6'd8;
            r_grid_tiles <= 7'd16;
            r_band_count <= 4'd10;
        end else begin
            r_state     <= n_state;
            r_p_v       <= n_p_v;
            r_out_valid <= n_out_valid;
            if (n_set_ready) r_grid_ready <= 1'b1;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_ROWS: begin
                        r_grid_rows  <= i_cfg_data[5:0];
                        r_grid_ready <= 1'b0;
                    end
                    CFG_TILES: begin
                        r_grid_tiles <= i_cfg_data;
                        r_grid_ready <= 1'b0;
                    end
                    CFG_BANDS: begin
                        r_band_count <= i_cfg_data[3:0];
                        r_grid_ready <= 1'b0;
                    end
                    default: r_grid_ready <= r_grid_ready;
                endcase
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_addr      <= n_addr;
        r_rd_zero   <= n_rd_zero;
        r_cnt       <= n_cnt;
        r_p_addr    <= n_p_addr;
        r_row       <= n_row;
        r_col       <= n_col;
        r_idx       <= n_idx;
        r_q         <= n_q;
        r_rem       <= n_rem;
        r_cband     <= n_cband;
        r_out_tier  <= n_out_tier;
        r_out_level <= n_out_level;
        if (accept) begin
            r_lvl[0] <= i_band_0;
            r_lvl[1] <= i_band_1;
            r_lvl[2] <= i_band_2;
            r_lvl[3] <= i_band_3;
            r_lvl[4] <= i_band_4;
            r_lvl[5] <= i_band_5;
            r_lvl[6] <= i_band_6;
            r_lvl[7] <= i_band_7;
            r_lvl[8] <= i_band_8;
            r_lvl[9] <= i_band_9;
        end
    end

    thid_mem #(
        .DEPTH (MAX_CELLS),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    thid_lcg u_lcg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (lcg_ctrl),
        .o_stat  (lcg_stat)
    );

    assign o_ready           = (r_state == S_IDLE);
    assign o_valid           = r_out_valid;
    assign o_brightness_tier = r_out_tier;
    assign o_cell_level      = r_out_level;

    // A new result only comes from the read completion state.
    a_out_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(r_state) == S_RD_OUT)
        else $error("result appeared outside a read");

    // The LCG finishes a draw only while generation waits for it.
    a_lcg_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        lcg_stat.done |-> (r_state == S_GEN_JIT || r_state == S_GEN_THR))
        else $error("LCG draw finished outside generation");

    // The tick write-back pipeline is empty outside a tick.
    a_tick_pipe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != S_TICK |-> !r_p_v)
        else $error("tick write-back pending outside a tick");

endmodule

@@ rtl/core/thid_lcg.sv @@
`timescale 1ns / 1ps
// ============================================================================
// thid_lcg
// 64-bit LCG stepped on one shared 32x32 multiplier in phases MUL0 to MUL2,
// then the remainder of (state >> 33) by 5 or by 1000 in phases DIV and MOD: a
// reciprocal multiplication for the quotient and a subtract for the remainder.
// ============================================================================
module thid_lcg (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  thid_pkg::t_lcg_ctrl i_ctrl,
    output thid_pkg::t_lcg_stat o_stat
);
    import thid_pkg::*;

    t_lcg_ph     r_ph;
    logic [63:0] r_s;
    logic [63:0] r_acc;
    logic [28:0] r_quo;
    logic [9:0]  r_rem;
    logic        r_thou;
    logic        r_done;

    logic [31:0] mul_a;
    logic [31:0] mul_b;
    logic [63:0] prod;
    logic [30:0] draw;
    logic [31:0] hi_sum;
    logic [28:0] quo;
    logic [30:0] qd;
    logic [30:0] rem_full;

    // Shared multiplier operand selection and remainder arithmetic.
    always_comb begin
        draw    = r_s[63:33];
        if (r_ph == L_MUL1)     mul_a = r_s[63:32];
        else if (r_ph == L_DIV) mul_a = {1'b0, draw};
        else                    mul_a = r_s[31:0];
        if (r_ph == L_MUL2)     mul_b = LCG_MUL[63:32];
        else if (r_ph == L_DIV) mul_b = r_thou ? LCG_RCP1K : LCG_RCP5;
        else                    mul_b = LCG_MUL[31:0];
        prod    = 64'(mul_a) * 64'(mul_b);
        hi_sum  = r_acc[63:32] + prod[31:0];
        quo     = r_thou ? 29'(prod >> LCG_RCP1K_SH) : 29'(prod >> LCG_RCP5_SH);
        // Quotient times the divisor: 1000q = 1024q - 16q - 8q, 5q = 4q + q.
        qd      = r_thou ? (31'(r_quo) << 10) - (31'(r_quo) << 4) - (31'(r_quo) << 3)
                         : (31'(r_quo) << 2) + 31'(r_quo);
        rem_full = draw - qd;
    end

    // Phase control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ph   <= L_IDLE;
            r_done <= 1'b0;
            r_s    <= LCG_SEED;
        end else begin
            r_done <= 1'b0;
            unique case (r_ph)
                L_IDLE: begin
                    if (i_ctrl.start) begin
                        if (i_ctrl.seed) r_s <= LCG_SEED;
                        r_ph <= L_MUL0;
                    end
                end
                L_MUL0: r_ph <= L_MUL1;
                L_MUL1: r_ph <= L_MUL2;
                L_MUL2: begin
                    r_s  <= {hi_sum, r_acc[31:0]};
                    r_ph <= L_DIV;
                end
                L_DIV: r_ph <= L_MOD;
                L_MOD: begin
                    r_done <= 1'b1;
                    r_ph   <= L_IDLE;
                end
                default: r_ph <= L_IDLE;
            endcase
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        if (r_ph == L_IDLE && i_ctrl.start) r_thou <= i_ctrl.thou;
        if (r_ph == L_MUL0) r_acc <= prod + LCG_INC;
        if (r_ph == L_MUL1) r_acc[63:32] <= hi_sum;
        if (r_ph == L_DIV) r_quo <= quo;
        if (r_ph == L_MOD) r_rem <= rem_full[9:0];
    end

    assign o_stat.done = r_done;
    assign o_stat.rem  = r_rem;

endmodule

@@ rtl/core/thid_mem.sv @@
`timescale 1ns / 1ps
// ============================================================================
// thid_mem
// Cell store: one write port and one read port with registered read data.
// ============================================================================
module thid_mem #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  logic                i_clk,
    input  logic                i_we,
    input  logic [AW-1:0]       i_waddr,
    input  thid_pkg::t_cell     i_wdata,
    input  logic [AW-1:0]       i_raddr,
    output thid_pkg::t_cell     o_rdata
);
    import thid_pkg::*;

    t_cell r_mem [DEPTH];

    // Synchronous write and read.
    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        o_rdata <= r_mem[i_raddr];
    end

endmodule
